// ===== rtl/mwm_pkg.sv =====
// Types and constants shared by the mecanum wheel mixer modules.
`timescale 1ns / 1ps
`default_nettype none

package mwm_pkg;

  localparam int IN_W       = 16;
  localparam int SUM_W      = 18;
  localparam int MAG_W      = 17;
  localparam int DUTY_W     = 7;
  localparam int PROD_W     = MAG_W + DUTY_W;
  localparam int Q_W        = 7;
  localparam int NUM_WHEELS = 4;
  localparam int DIV_STEPS  = Q_W;
  localparam int SHIFT_W    = 3;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  localparam logic [0:0] CFG_ENABLE     = 1'b0;
  localparam logic [0:0] CFG_FULL_SCALE = 1'b1;

  localparam int WHEEL_FL = 0;
  localparam int WHEEL_FR = 1;
  localparam int WHEEL_RL = 2;
  localparam int WHEEL_RR = 3;

  typedef struct packed {
    logic signed [IN_W-1:0] vel_x;
    logic signed [IN_W-1:0] vel_y;
    logic signed [IN_W-1:0] rot_rate;
  } cmd_t;

  typedef struct packed {
    logic              status;
    logic [DUTY_W-1:0] front_left_fwd;
    logic [DUTY_W-1:0] front_left_rev;
    logic [DUTY_W-1:0] front_right_fwd;
    logic [DUTY_W-1:0] front_right_rev;
    logic [DUTY_W-1:0] rear_left_fwd;
    logic [DUTY_W-1:0] rear_left_rev;
    logic [DUTY_W-1:0] rear_right_fwd;
    logic [DUTY_W-1:0] rear_right_rev;
  } duty_t;

  typedef struct packed {
    logic                                  status;
    logic [NUM_WHEELS-1:0]                 pos;
    logic [NUM_WHEELS-1:0]                 neg;
    logic [MAG_W-1:0]                      den;
    logic [NUM_WHEELS-1:0][PROD_W-1:0]     rem;
    logic [NUM_WHEELS-1:0][Q_W-1:0]        quo;
  } div_t;

endpackage

`default_nettype wire

// ===== rtl/mwm_div_stage.sv =====
// One registered restoring-division stage that resolves one quotient bit for all wheels.
`timescale 1ns / 1ps
`default_nettype none

module mwm_div_stage
  import mwm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire logic               src_valid,
  input  wire div_t               src,
  input  wire logic [SHIFT_W-1:0] shift,
  output logic                    dst_valid,
  output div_t                    dst
);

  logic [PROD_W-1:0] den_sh;
  div_t              dst_next;

  always_comb begin
    den_sh   = PROD_W'(src.den) << shift;
    dst_next = src;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      if (src.rem[w] >= den_sh) begin
        dst_next.rem[w] = src.rem[w] - den_sh;
        dst_next.quo[w] = src.quo[w] | (Q_W'(1) << shift);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (load) begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dst <= dst_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mecanum_wheel_mixer.sv =====
// Top level of the mecanum wheel mixer: wheel sums, normalization and leg duties.
`timescale 1ns / 1ps
`default_nettype none

// The mixer takes one velocity command per clock cycle while cmd_stall is low and returns one
// result per command in order. Three stages form the wheel sums, their magnitudes, the
// products with the full-scale duty and the pairwise larger magnitudes; one stage finds the
// largest magnitude and picks the divisor; seven compare-subtract stages then resolve the
// quotient one bit each, and the last of them is the output register. Every stage holds its
// own valid bit, so a stall at the output only backs up as far as the pipeline is full and
// bubbles are squeezed out. Configuration is written through a plain write port and takes
// effect for commands accepted afterwards.
module mecanum_wheel_mixer
  import mwm_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [DUTY_W-1:0] cfg_data,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  wire cmd_t              cmd,
  output logic                   duty_valid,
  input  wire logic              duty_stall,
  output duty_t                  duty
);

  localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << FRAC_BITS;
  localparam int LAST = 4 + DIV_STEPS;

  typedef struct packed {
    logic                                    status;
    logic [DUTY_W-1:0]                       fs;
    logic [NUM_WHEELS-1:0][SUM_W-1:0]        sum;
  } s1_t;

  typedef struct packed {
    logic                                    status;
    logic [DUTY_W-1:0]                       fs;
    logic [NUM_WHEELS-1:0]                   pos;
    logic [NUM_WHEELS-1:0]                   neg;
    logic [NUM_WHEELS-1:0][MAG_W-1:0]        mag;
  } s2_t;

  typedef struct packed {
    logic                                    status;
    logic [NUM_WHEELS-1:0]                   pos;
    logic [NUM_WHEELS-1:0]                   neg;
    logic [MAG_W-1:0]                        max01;
    logic [MAG_W-1:0]                        max23;
    logic [NUM_WHEELS-1:0][PROD_W-1:0]       prod;
  } s3_t;

  logic              enable;
  logic [DUTY_W-1:0] full_scale;

  logic [LAST:0]   v;
  logic [1:LAST+1] ready;

  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;
  div_t dv [0:DIV_STEPS];
  div_t dv_next;

  logic signed [SUM_W-1:0] ex, ey, er;
  logic [MAG_W-1:0]        max_all;
  div_t                    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      full_scale <= DUTY_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:     enable     <= cfg_data[0];
        CFG_FULL_SCALE: full_scale <= cfg_data;
        default:        enable     <= enable;
      endcase
    end
  end

  always_comb begin
    ready[LAST+1] = !duty_stall;
    for (int i = LAST; i >= 1; i--) begin
      ready[i] = !v[i] || ready[i+1];
    end
  end

  assign v[0]      = cmd_valid;
  assign cmd_stall = !ready[1];

  for (genvar i = 1; i <= 4; i++) begin : g_front
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (ready[i]) begin
        v[i] <= v[i-1];
      end
    end
  end

  always_comb begin
    ex = SUM_W'(cmd.vel_x);
    ey = SUM_W'(cmd.vel_y);
    er = SUM_W'(cmd.rot_rate);
    s1_next.status = !enable;
    if (!enable) begin
      s1_next.fs = '0;
    end else if (full_scale > DUTY_MAX) begin
      s1_next.fs = DUTY_MAX;
    end else begin
      s1_next.fs = full_scale;
    end
    s1_next.sum[WHEEL_FL] = ey + ex + er;
    s1_next.sum[WHEEL_FR] = ey - ex - er;
    s1_next.sum[WHEEL_RL] = ey - ex + er;
    s1_next.sum[WHEEL_RR] = ey + ex - er;
  end

  always_comb begin
    s2_next.status = s1.status;
    s2_next.fs     = s1.fs;
    for (int w = 0; w < NUM_WHEELS; w++) begin
      s2_next.neg[w] = s1.sum[w][SUM_W-1];
      s2_next.pos[w] = !s1.sum[w][SUM_W-1] && (s1.sum[w] != '0);
      s2_next.mag[w] = s1.sum[w][SUM_W-1] ? MAG_W'(-s1.sum[w]) : MAG_W'(s1.sum[w]);
    end
  end

  always_comb begin
    s3_next.status = s2.status;
    s3_next.pos    = s2.pos;
    s3_next.neg    = s2.neg;
    s3_next.max01  = (s2.mag[0] > s2.mag[1]) ? s2.mag[0] : s2.mag[1];
    s3_next.max23  = (s2.mag[2] > s2.mag[3]) ? s2.mag[2] : s2.mag[3];
    for (int w = 0; w < NUM_WHEELS; w++) begin
      s3_next.prod[w] = PROD_W'(s2.mag[w]) * PROD_W'(s2.fs);
    end
  end

  always_comb begin
    max_all        = (s3.max01 > s3.max23) ? s3.max01 : s3.max23;
    dv_next.status = s3.status;
    dv_next.pos    = s3.pos;
    dv_next.neg    = s3.neg;
    dv_next.den    = (max_all > ONE) ? max_all : ONE;
    dv_next.rem    = s3.prod;
    dv_next.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      s1 <= s1_next;
    end
    if (ready[2]) begin
      s2 <= s2_next;
    end
    if (ready[3]) begin
      s3 <= s3_next;
    end
    if (ready[4]) begin
      dv[0] <= dv_next;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    mwm_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .load      (ready[5+j]),
      .src_valid (v[4+j]),
      .src       (dv[j]),
      .shift     (SHIFT_W'(DIV_STEPS - 1 - j)),
      .dst_valid (v[5+j]),
      .dst       (dv[j+1])
    );
  end

  assign res        = dv[DIV_STEPS];
  assign duty_valid = v[LAST];

  always_comb begin
    duty.status          = res.status;
    duty.front_left_fwd  = res.pos[WHEEL_FL] ? res.quo[WHEEL_FL] : '0;
    duty.front_left_rev  = res.neg[WHEEL_FL] ? res.quo[WHEEL_FL] : '0;
    duty.front_right_fwd = res.pos[WHEEL_FR] ? res.quo[WHEEL_FR] : '0;
    duty.front_right_rev = res.neg[WHEEL_FR] ? res.quo[WHEEL_FR] : '0;
    duty.rear_left_fwd   = res.pos[WHEEL_RL] ? res.quo[WHEEL_RL] : '0;
    duty.rear_left_rev   = res.neg[WHEEL_RL] ? res.quo[WHEEL_RL] : '0;
    duty.rear_right_fwd  = res.pos[WHEEL_RR] ? res.quo[WHEEL_RR] : '0;
    duty.rear_right_rev  = res.neg[WHEEL_RR] ? res.quo[WHEEL_RR] : '0;
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    duty_valid && duty.status |-> duty.front_left_fwd == '0 && duty.front_left_rev == '0
      && duty.front_right_fwd == '0 && duty.front_right_rev == '0
      && duty.rear_left_fwd == '0 && duty.rear_left_rev == '0
      && duty.rear_right_fwd == '0 && duty.rear_right_rev == '0)
    else $error("Rejected item carries a nonzero duty.");

  a_one_leg: assert property (@(posedge clk) disable iff (rst)
    duty_valid |-> !(duty.front_left_fwd != '0 && duty.front_left_rev != '0)
      && !(duty.front_right_fwd != '0 && duty.front_right_rev != '0)
      && !(duty.rear_left_fwd != '0 && duty.rear_left_rev != '0)
      && !(duty.rear_right_fwd != '0 && duty.rear_right_rev != '0))
    else $error("Both legs of one bridge are driven.");

  a_duty_max: assert property (@(posedge clk) disable iff (rst)
    duty_valid |-> res.quo[WHEEL_FL] <= DUTY_MAX && res.quo[WHEEL_FR] <= DUTY_MAX
      && res.quo[WHEEL_RL] <= DUTY_MAX && res.quo[WHEEL_RR] <= DUTY_MAX)
    else $error("Duty exceeds the full-scale limit.");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    duty_valid |-> res.rem[WHEEL_FL] < PROD_W'(res.den) && res.rem[WHEEL_FR] < PROD_W'(res.den)
      && res.rem[WHEEL_RL] < PROD_W'(res.den) && res.rem[WHEEL_RR] < PROD_W'(res.den))
    else $error("Division remainder is not below the divisor.");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !duty_valid)
    else $error("Result shown right after reset.");

endmodule

`default_nettype wire
